// ===== sv/tcff_pkg.sv =====
`timescale 1ns / 1ps
package tcff_pkg;

  localparam int unsigned DAY_BITS  = 16;
  localparam int unsigned LOAD_W    = 19;
  localparam int unsigned ACC_W     = 40;
  localparam int unsigned PERF_W    = 34;
  localparam int unsigned COMP_W    = 36;
  localparam int unsigned IDX_W     = 16;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PROD_W    = 58;
  localparam int unsigned SUM_W     = 52;

  localparam logic [CFG_IDX_W-1:0] REG_AER_COEF  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GLY_COEF  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEU_COEF  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AER_START = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GLY_START = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NEU_START = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS   = 3'd6;

  localparam logic [47:0] WEIGHTS_RESET = 48'd42221031817216;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_FIT_DECAY,
    OP_FAT_DECAY,
    OP_FIT_GAIN,
    OP_FAT_GAIN,
    OP_WEIGHT
  } op_e;

  typedef struct packed {
    logic       start;
    logic       finish;
    op_e        op;
    logic [1:0] comp;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } status_t;

endpackage

// ===== sv/tcff_if.sv =====
`timescale 1ns / 1ps
interface tcff_in_if;
  logic        valid;
  logic        ready;
  logic [18:0] aerobic_load;
  logic [18:0] glycolytic_load;
  logic [18:0] neuro_load;
  logic        first_day;

  modport source (output valid, aerobic_load, glycolytic_load, neuro_load, first_day,
                  input ready);
  modport sink (input valid, aerobic_load, glycolytic_load, neuro_load, first_day,
                output ready);
endinterface

interface tcff_out_if;
  logic               valid;
  logic               ready;
  logic signed [33:0] aerobic_perf;
  logic signed [33:0] glycolytic_perf;
  logic signed [33:0] neuro_perf;
  logic signed [35:0] composite_perf;
  logic signed [35:0] best_perf;
  logic [15:0]        best_day;
  logic [15:0]        day_number;

  modport source (output valid, aerobic_perf, glycolytic_perf, neuro_perf, composite_perf,
                  best_perf, best_day, day_number, input ready);
  modport sink (input valid, aerobic_perf, glycolytic_perf, neuro_perf, composite_perf,
                best_perf, best_day, day_number, output ready);
endinterface

// ===== sv/tcff_ctrl.sv =====
`timescale 1ns / 1ps
module tcff_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tcff_pkg::status_t status_i,
  output tcff_pkg::cmd_t   cmd_o
);
  import tcff_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_DONE} state_e;

  state_e     state_q;
  logic [1:0] comp_q;
  logic [2:0] phase_q;

  always_comb begin
    cmd_o      = '0;
    cmd_o.op   = OP_NONE;
    cmd_o.comp = comp_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      S_RUN: begin
        unique case (phase_q)
          3'd0:    cmd_o.op = OP_FIT_DECAY;
          3'd1:    cmd_o.op = OP_FAT_DECAY;
          3'd2:    cmd_o.op = OP_FIT_GAIN;
          3'd3:    cmd_o.op = OP_FAT_GAIN;
          3'd5:    cmd_o.op = OP_WEIGHT;
          default: cmd_o.op = OP_NONE;
        endcase
      end
      S_DRAIN: cmd_o.op = OP_NONE;
      S_DONE:  cmd_o.finish = !status_i.out_full;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      comp_q  <= '0;
      phase_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_RUN;
            comp_q  <= '0;
            phase_q <= '0;
          end
        end
        S_RUN: begin
          if (phase_q == 3'd5) begin
            phase_q <= '0;
            if (comp_q == 2'd2) begin
              state_q <= S_DRAIN;
            end else begin
              comp_q <= comp_q + 2'd1;
            end
          end else begin
            phase_q <= phase_q + 3'd1;
          end
        end
        S_DRAIN: state_q <= S_DONE;
        S_DONE: begin
          if (!status_i.out_full) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/tcff_datapath.sv =====
`timescale 1ns / 1ps
module tcff_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tcff_pkg::cmd_t                   cmd_i,
  output tcff_pkg::status_t                status_o,
  input  logic                             cfg_we_i,
  input  logic [tcff_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tcff_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic [tcff_pkg::LOAD_W-1:0]      aer_load_i,
  input  logic [tcff_pkg::LOAD_W-1:0]      gly_load_i,
  input  logic [tcff_pkg::LOAD_W-1:0]      neu_load_i,
  input  logic                             first_day_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [tcff_pkg::PERF_W-1:0] aer_perf_o,
  output logic signed [tcff_pkg::PERF_W-1:0] gly_perf_o,
  output logic signed [tcff_pkg::PERF_W-1:0] neu_perf_o,
  output logic signed [tcff_pkg::COMP_W-1:0] comp_perf_o,
  output logic signed [tcff_pkg::COMP_W-1:0] best_perf_o,
  output logic [tcff_pkg::IDX_W-1:0]       best_day_o,
  output logic [tcff_pkg::IDX_W-1:0]       day_num_o
);
  import tcff_pkg::*;

  logic [CFG_W-1:0]  coef_q [3];
  logic [CFG_W-1:0]  start_q [3];
  logic [47:0]       wts_q;

  logic [ACC_W-1:0]  fit_q [3];
  logic [ACC_W-1:0]  fat_q [3];
  logic [LOAD_W-1:0] load_q [3];
  logic signed [PERF_W-1:0] perf_q [3];
  logic signed [PROD_W-1:0] pf_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0]  sum_q;
  op_e               op_q;
  logic [1:0]        comp_q;

  logic signed [COMP_W-1:0] peak_q;
  logic [DAY_BITS-1:0]      peak_idx_q;
  logic [DAY_BITS-1:0]      day_q;
  logic                     out_valid_q;

  logic [15:0]              mul_a;
  logic signed [40:0]       mul_b;
  logic [63:0]              coef_sel;
  logic [ACC_W:0]           acc_sum;
  logic [ACC_W-1:0]         acc_sat;
  logic [LOAD_W-1:0]        load_sel;
  logic signed [PROD_W-1:0] diff;
  logic signed [COMP_W-1:0] composite;
  logic [31:0]              day_ext;
  logic [31:0]              peak_ext;

  assign coef_sel = coef_q[cmd_i.comp];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_FIT_DECAY: begin
        mul_a = coef_sel[15:0];
        mul_b = signed'({1'b0, fit_q[cmd_i.comp]});
      end
      OP_FAT_DECAY: begin
        mul_a = coef_sel[31:16];
        mul_b = signed'({1'b0, fat_q[cmd_i.comp]});
      end
      OP_FIT_GAIN: begin
        mul_a = coef_sel[47:32];
        mul_b = signed'({1'b0, fit_q[cmd_i.comp]});
      end
      OP_FAT_GAIN: begin
        mul_a = coef_sel[63:48];
        mul_b = signed'({1'b0, fat_q[cmd_i.comp]});
      end
      OP_WEIGHT: begin
        mul_a = wts_q[16*cmd_i.comp +: 16];
        mul_b = 41'(perf_q[cmd_i.comp]);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign load_sel = load_q[comp_q];
  assign acc_sum  = {1'b0, prod_q[55:16]} + {6'b0, load_sel, 16'b0};
  assign acc_sat  = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
  assign diff     = pf_q - prod_q;
  assign composite = sum_q[SUM_W-1:16];
  assign day_ext  = 32'(day_q);
  assign peak_ext = 32'(peak_idx_q);

  assign status_o.out_full = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        coef_q[i]  <= '0;
        start_q[i] <= '0;
        fit_q[i]   <= '0;
        fat_q[i]   <= '0;
      end
      wts_q       <= WEIGHTS_RESET;
      op_q        <= OP_NONE;
      comp_q      <= '0;
      peak_q      <= {1'b1, {(COMP_W-1){1'b0}}};
      peak_idx_q  <= '0;
      day_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_AER_COEF:  coef_q[0]  <= cfg_data_i;
          REG_GLY_COEF:  coef_q[1]  <= cfg_data_i;
          REG_NEU_COEF:  coef_q[2]  <= cfg_data_i;
          REG_AER_START: start_q[0] <= cfg_data_i;
          REG_GLY_START: start_q[1] <= cfg_data_i;
          REG_NEU_START: start_q[2] <= cfg_data_i;
          REG_WEIGHTS:   wts_q      <= cfg_data_i[47:0];
          default:       wts_q      <= wts_q;
        endcase
      end

      op_q   <= cmd_i.op;
      comp_q <= cmd_i.comp;
      prod_q <= signed'({1'b0, mul_a}) * mul_b;

      if (cmd_i.start && first_day_i) begin
        for (int i = 0; i < 3; i++) begin
          fit_q[i] <= {start_q[i][31:0], 8'b0};
          fat_q[i] <= {start_q[i][63:32], 8'b0};
        end
        peak_q     <= {1'b1, {(COMP_W-1){1'b0}}};
        peak_idx_q <= '0;
        day_q      <= '0;
      end

      unique case (op_q)
        OP_FIT_DECAY: fit_q[comp_q] <= acc_sat;
        OP_FAT_DECAY: fat_q[comp_q] <= acc_sat;
        default: begin
        end
      endcase

      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        if (composite > peak_q) begin
          peak_q     <= composite;
          peak_idx_q <= day_q;
        end
        if (day_q != {DAY_BITS{1'b1}}) begin
          day_q <= day_q + 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      load_q[0] <= aer_load_i;
      load_q[1] <= gly_load_i;
      load_q[2] <= neu_load_i;
      sum_q     <= '0;
    end
    unique case (op_q)
      OP_FIT_GAIN: pf_q <= prod_q;
      OP_FAT_GAIN: perf_q[comp_q] <= diff[PROD_W-1:24];
      OP_WEIGHT:   sum_q <= sum_q + prod_q[SUM_W-1:0];
      default: begin
      end
    endcase
    if (cmd_i.finish) begin
      aer_perf_o  <= perf_q[0];
      gly_perf_o  <= perf_q[1];
      neu_perf_o  <= perf_q[2];
      comp_perf_o <= composite;
      day_num_o   <= (day_ext > 32'hFFFF) ? 16'hFFFF : day_ext[15:0];
      if (composite > peak_q) begin
        best_perf_o <= composite;
        best_day_o  <= (day_ext > 32'hFFFF) ? 16'hFFFF : day_ext[15:0];
      end else begin
        best_perf_o <= peak_q;
        best_day_o  <= (peak_ext > 32'hFFFF) ? 16'hFFFF : peak_ext[15:0];
      end
    end
  end

endmodule

// ===== sv/three_component_fitness_fatigue_filter.sv =====
`timescale 1ns / 1ps
// Three-component fitness/fatigue filter.
// Input channel in_s carries one word per day: three unsigned Q11.8 loads and a
// first_day flag that reloads the start values and restarts the peak and day count.
// Output channel out_s carries one word per input word: the three component
// performances, the weighted composite, the best composite of the run and its day,
// and the index of this day.
// The configuration port writes one register per cycle when cfg_we_i is high; it
// must only be written while the block is idle.
// For each accepted word, one shared 16 x 41 bit multiplier runs five products
// per component, six slots each with one slot spent on the performance
// subtract, followed by the drain and done states of the controller.
// The next word is accepted the cycle after the result is registered, so a
// new word is not taken while the previous one is still being computed.
// The result sits in an output register; while the receiver stalls, a new word
// may be taken and computed, and it waits in its last cycle until the
// register frees up.
// Reset clears accumulators, the peak (to the most negative value), the day
// count and the configuration (weights to 0.5, 0.35, 0.15).
module three_component_fitness_fatigue_filter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  tcff_in_if.sink                         in_s,
  tcff_out_if.source                      out_s,
  input  logic                            cfg_we_i,
  input  logic [tcff_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tcff_pkg::CFG_W-1:0]      cfg_data_i
);
  import tcff_pkg::*;

  cmd_t    cmd;
  status_t status;

  tcff_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_s.valid),
    .in_ready_o (in_s.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tcff_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .aer_load_i  (in_s.aerobic_load),
    .gly_load_i  (in_s.glycolytic_load),
    .neu_load_i  (in_s.neuro_load),
    .first_day_i (in_s.first_day),
    .out_valid_o (out_s.valid),
    .out_ready_i (out_s.ready),
    .aer_perf_o  (out_s.aerobic_perf),
    .gly_perf_o  (out_s.glycolytic_perf),
    .neu_perf_o  (out_s.neuro_perf),
    .comp_perf_o (out_s.composite_perf),
    .best_perf_o (out_s.best_perf),
    .best_day_o  (out_s.best_day),
    .day_num_o   (out_s.day_number)
  );

endmodule

// ===== sim/three_component_fitness_fatigue_filter_checker.sv =====
`timescale 1ns / 1ps
module three_component_fitness_fatigue_filter_checker
  import tcff_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tcff_in_if                   in_m,
  tcff_out_if                  out_m,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam logic [ACC_W-1:0] ACC_SAT = {ACC_W{1'b1}};
  localparam logic signed [COMP_W-1:0] PEAK_FLOOR = {1'b1, {(COMP_W-1){1'b0}}};
  localparam logic [DAY_BITS-1:0] DAY_LAST = {DAY_BITS{1'b1}};

  typedef struct {
    logic signed [PERF_W-1:0] aer;
    logic signed [PERF_W-1:0] gly;
    logic signed [PERF_W-1:0] neu;
    logic signed [COMP_W-1:0] comp;
    logic signed [COMP_W-1:0] best;
    logic [IDX_W-1:0]         best_day;
    logic [IDX_W-1:0]         day;
  } day_perf_t;

  logic [CFG_W-1:0]          regs [7];
  logic [ACC_W-1:0]          fit_acc [3];
  logic [ACC_W-1:0]          fat_acc [3];
  logic signed [COMP_W-1:0]  peak;
  logic [DAY_BITS-1:0]       peak_day;
  logic [DAY_BITS-1:0]       day_cnt;
  day_perf_t                 perf_q [$];

  function automatic logic [ACC_W-1:0] decay_add(logic [ACC_W-1:0] acc, logic [15:0] d,
                                                 logic [LOAD_W-1:0] load);
    logic [63:0] v;
    v = ((64'(acc) * 64'(d)) >> 16) + (64'(load) << 16);
    return (v > 64'(ACC_SAT)) ? ACC_SAT : v[ACC_W-1:0];
  endfunction

  // Advances the three filters by one day and returns the expected word.
  function day_perf_t predict_day(logic [LOAD_W-1:0] loads [3], logic first);
    day_perf_t r;
    longint    perf [3];
    longint    sum;
    longint    comp;
    logic [63:0] co;
    sum = 0;
    if (first) begin
      for (int c = 0; c < 3; c++) begin
        fit_acc[c] = {regs[3+c][31:0], 8'h00};
        fat_acc[c] = {regs[3+c][63:32], 8'h00};
      end
      peak = PEAK_FLOOR;
      peak_day = '0;
      day_cnt = '0;
    end
    for (int c = 0; c < 3; c++) begin
      co = regs[c];
      fit_acc[c] = decay_add(fit_acc[c], co[15:0], loads[c]);
      fat_acc[c] = decay_add(fat_acc[c], co[31:16], loads[c]);
      perf[c] = (longint'(64'(co[47:32]) * 64'(fit_acc[c]))
               - longint'(64'(co[63:48]) * 64'(fat_acc[c]))) >>> 24;
      sum += longint'(64'(regs[REG_WEIGHTS][16*c +: 16])) * perf[c];
    end
    comp = sum >>> 16;
    r.day = day_cnt;
    // A tie keeps the earlier day.
    if (comp > longint'(peak)) begin
      peak = comp[COMP_W-1:0];
      peak_day = day_cnt;
    end
    if (day_cnt != DAY_LAST) day_cnt++;
    r.aer = perf[0][PERF_W-1:0];
    r.gly = perf[1][PERF_W-1:0];
    r.neu = perf[2][PERF_W-1:0];
    r.comp = comp[COMP_W-1:0];
    r.best = peak;
    r.best_day = peak_day;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    day_perf_t exp_w;
    day_perf_t got;
    logic [LOAD_W-1:0] loads [3];
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) regs[i] = '0;
      regs[REG_WEIGHTS] = 64'(WEIGHTS_RESET);
      for (int c = 0; c < 3; c++) begin
        fit_acc[c] = '0;
        fat_acc[c] = '0;
      end
      peak = PEAK_FLOOR;
      peak_day = '0;
      day_cnt = '0;
      perf_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      // Index seven names no register and is dropped.
      if (cfg_we_i && cfg_idx_i <= REG_WEIGHTS) begin
        regs[cfg_idx_i] = (cfg_idx_i == REG_WEIGHTS) ? {16'h0, cfg_data_i[47:0]} : cfg_data_i;
      end
      if (in_m.valid && in_m.ready) begin
        loads[0] = in_m.aerobic_load;
        loads[1] = in_m.glycolytic_load;
        loads[2] = in_m.neuro_load;
        perf_q.push_back(predict_day(loads, in_m.first_day));
      end
      if (out_m.valid && out_m.ready) begin
        got.aer = out_m.aerobic_perf;
        got.gly = out_m.glycolytic_perf;
        got.neu = out_m.neuro_perf;
        got.comp = out_m.composite_perf;
        got.best = out_m.best_perf;
        got.best_day = out_m.best_day;
        got.day = out_m.day_number;
        if (perf_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result word at %0t", $realtime);
        end else begin
          exp_w = perf_q.pop_front();
          if (got.aer !== exp_w.aer || got.gly !== exp_w.gly || got.neu !== exp_w.neu ||
              got.comp !== exp_w.comp || got.best !== exp_w.best ||
              got.best_day !== exp_w.best_day || got.day !== exp_w.day) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("mismatch at %0t: expected perf %0d %0d %0d comp %0d best %0d@%0d day %0d",
                       $realtime, exp_w.aer, exp_w.gly, exp_w.neu, exp_w.comp, exp_w.best,
                       exp_w.best_day, exp_w.day);
              $display("             actual   perf %0d %0d %0d comp %0d best %0d@%0d day %0d",
                       got.aer, got.gly, got.neu, got.comp, got.best, got.best_day, got.day);
            end
          end
        end
      end
      pending_o = perf_q.size();
    end
  end

endmodule

// ===== sim/three_component_fitness_fatigue_filter_test.sv =====
`timescale 1ns / 1ps
module three_component_fitness_fatigue_filter_test;
  import tcff_pkg::*;

  // Index seven decodes to no register; writes to it must have no effect.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};
  // The drain pause and the watchdog leave plenty of room above the time the
  // block needs per word, even with a receiver that stalls half the time.
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT = 4000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;
  int fail_count;
  int pending;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles = 0;

  tcff_in_if in_c ();
  tcff_out_if out_c ();

  three_component_fitness_fatigue_filter u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_s      (in_c),
    .out_s     (out_c),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  three_component_fitness_fatigue_filter_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_m        (in_c),
    .out_m       (out_c),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // The receiver stalls at random with the probability of the current phase.
  always @(posedge clk_i) begin
    out_c.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: too many cycles without a word moving on either channel ends the run.
  always @(posedge clk_i) begin
    if ((in_c.valid && in_c.ready) || (out_c.valid && out_c.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("three_component_fitness_fatigue_filter_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one day and holds it until accepted. Valid stays high afterwards;
  // it is only lowered when the sender idles before the next word or drains.
  task automatic send_day(logic [LOAD_W-1:0] a, logic [LOAD_W-1:0] g,
                          logic [LOAD_W-1:0] n, logic first);
    if ($urandom_range(99) < send_idle_pct) begin
      in_c.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_c.valid <= 1'b1;
    in_c.aerobic_load <= a;
    in_c.glycolytic_load <= g;
    in_c.neuro_load <= n;
    in_c.first_day <= first;
    @(posedge clk_i);
    while (!in_c.ready) @(posedge clk_i);
  endtask

  // Lets every outstanding word come back, then a few more cycles so the block
  // is truly idle before configuration changes.
  task automatic drain();
    in_c.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Writes a full register set and index seven back to back, then closes the port.
  task automatic load_regs(logic [CFG_W-1:0] coef [3], logic [CFG_W-1:0] start [3],
                           logic [CFG_W-1:0] weights);
    for (int i = 0; i < 3; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= REG_AER_COEF + CFG_IDX_W'(i);
      cfg_data_i <= coef[i];
      @(posedge clk_i);
      cfg_idx_i <= REG_AER_START + CFG_IDX_W'(i);
      cfg_data_i <= start[i];
      @(posedge clk_i);
    end
    cfg_idx_i <= REG_WEIGHTS;
    cfg_data_i <= weights;
    @(posedge clk_i);
    cfg_idx_i <= REG_UNUSED;
    cfg_data_i <= {$urandom, $urandom};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [LOAD_W-1:0] pick_load();
    case ($urandom_range(9))
      0: return '0;
      1: return LOAD_MAX;
      2, 3: return LOAD_W'($urandom_range(4095));
      default: return LOAD_W'($urandom);
    endcase
  endfunction

  // Random coefficients: decays mostly near one so the filters build up and
  // sometimes saturate, gains anywhere in their range.
  function automatic logic [CFG_W-1:0] pick_coef();
    logic [15:0] f [4];
    for (int k = 0; k < 4; k++) begin
      f[k] = 16'($urandom);
      if (k < 2 && $urandom_range(3) != 0) f[k] = 16'($urandom_range(16'hFFFF, 16'hE000));
    end
    return {f[3], f[2], f[1], f[0]};
  endfunction

  initial begin
    logic [CFG_W-1:0] coef [3];
    logic [CFG_W-1:0] start [3];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_c.valid = 1'b0;
    in_c.aerobic_load = '0;
    in_c.glycolytic_load = '0;
    in_c.neuro_load = '0;
    in_c.first_day = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. First the reset configuration, with no first-day word:
    // all gains are zero, so every composite ties at zero and day 0 stays best.
    send_day('0, '0, '0, 1'b0);
    send_day(LOAD_MAX, LOAD_MAX, LOAD_MAX, 1'b0);
    send_day('0, '0, '0, 1'b0);
    drain();

    // Full-scale coefficients and starts: decays just below one with maximum
    // loads drive every accumulator into saturation.
    for (int c = 0; c < 3; c++) begin
      coef[c] = '1;
      start[c] = '1;
    end
    load_regs(coef, start, '1);
    send_day(LOAD_MAX, LOAD_MAX, LOAD_MAX, 1'b1);
    repeat (4) send_day(LOAD_MAX, LOAD_MAX, LOAD_MAX, 1'b0);
    send_day('0, '0, '0, 1'b0);
    send_day('0, '0, '0, 1'b1);
    drain();

    // Fatigue gain above fitness gain gives negative performances; the peak
    // must then be the least negative composite, and equal ones keep the day.
    coef[0] = {16'hFFFF, 16'h1000, 16'hFFFF, 16'hF000};
    coef[1] = {16'h8000, 16'h0001, 16'hC000, 16'hC000};
    coef[2] = {16'hFFFF, 16'h0000, 16'h0000, 16'h0000};
    start[0] = {32'h0001_0000, 32'h0000_8000};
    start[1] = {32'hFFFF_FFFF, 32'h0000_0000};
    start[2] = '0;
    load_regs(coef, start, 64'({16'hFFFF, 16'h0000, 16'hFFFF}));
    send_day(19'h100, 19'h200, LOAD_MAX, 1'b1);
    send_day(19'h100, 19'h200, '0, 1'b0);
    send_day('0, '0, '0, 1'b0);
    send_day('0, '0, '0, 1'b0);
    send_day(LOAD_MAX, '0, 19'h55555, 1'b0);
    send_day(19'h2AAAA, LOAD_MAX, 19'h2AAAA, 1'b1);
    drain();

    // All zero: decays of zero discard history, zero weights null the composite.
    for (int c = 0; c < 3; c++) begin
      coef[c] = '0;
      start[c] = '0;
    end
    load_regs(coef, start, '0);
    send_day(LOAD_MAX, 19'h55555, 19'h2AAAA, 1'b1);
    send_day(19'h1, 19'h1, 19'h1, 1'b0);
    drain();

    // Random part in four idling phases, each with its own configuration.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      for (int c = 0; c < 3; c++) begin
        coef[c] = pick_coef();
        start[c] = {$urandom, $urandom};
      end
      load_regs(coef, start, {$urandom, $urandom});
      // A new run opens each phase; occasional restarts come later on.
      send_day(pick_load(), pick_load(), pick_load(), 1'b1);
      for (int i = 0; i < 232; i++) begin
        send_day(pick_load(), pick_load(), pick_load(), $urandom_range(39) == 0);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("three_component_fitness_fatigue_filter_test OK");
    end else begin
      $display("three_component_fitness_fatigue_filter_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tcff_pkg.sv
sv/tcff_if.sv
sv/tcff_ctrl.sv
sv/tcff_datapath.sv
sv/three_component_fitness_fatigue_filter.sv
sim/three_component_fitness_fatigue_filter_checker.sv
sim/three_component_fitness_fatigue_filter_test.sv
